// ===== src/pbs_pkg.sv =====
// pbs_pkg: types and constants shared by the pixel buffer store modules.
// Beat payload structs, operation and register codes, controller links.
// No dependencies.
`timescale 1ns / 1ps

package pbs_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PUT   = 2'd1;
    localparam logic [1:0] OP_GET   = 2'd2;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam int          CFG_W         = 9;
    localparam logic [8:0]  CFG_RESET_DIM = 9'd256;

    localparam logic [11:0] DEF_RED       = 12'd2055;
    localparam logic [11:0] DEF_GREEN     = 12'd1798;
    localparam logic [11:0] DEF_BLUE      = 12'd1541;
    localparam logic [15:0] DEF_ALPHA     = 16'hFFFF;
    localparam logic [31:0] DEF_DEPTH     = 32'h7FFF_FFFF;
    localparam logic [11:0] INTENSITY_MAX = 12'd4095;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] column;
        logic signed [15:0] row;
        logic signed [15:0] red_in;
        logic signed [15:0] green_in;
        logic signed [15:0] blue_in;
        logic signed [15:0] alpha_in;
        logic signed [31:0] depth_in;
    } t_in_beat;

    typedef struct packed {
        logic               status;
        logic [11:0]        red_out;
        logic [11:0]        green_out;
        logic [11:0]        blue_out;
        logic signed [15:0] alpha_out;
        logic signed [31:0] depth_out;
        logic [7:0]         red_byte;
        logic [7:0]         green_byte;
        logic [7:0]         blue_byte;
    } t_out_beat;

    typedef struct packed {
        logic [11:0] red;
        logic [11:0] green;
        logic [11:0] blue;
        logic [15:0] alpha;
        logic [31:0] depth;
    } t_pixel;

    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic put_wr;
        logic rd_en;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_op;
        logic       in_oor;
        logic       clr_empty;
        logic       clr_last;
        logic       out_free;
    } t_sts;

endpackage

// ===== src/pbs_ctrl.sv =====
// pbs_ctrl: operation sequencer for the pixel buffer store.
// Drives datapath commands from its status; uses pbs_pkg.
`timescale 1ns / 1ps

module pbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pbs_pkg::t_sts i_sts,
    output pbs_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_sts.in_op)
                        pbs_pkg::OP_CLEAR: n_state = i_sts.clr_empty ? S_RESP : S_CLEAR;
                        pbs_pkg::OP_PUT:   n_state = i_sts.in_oor ? S_RESP : S_PUT;
                        pbs_pkg::OP_GET:   n_state = i_sts.in_oor ? S_RESP : S_READ;
                        default:           n_state = S_RESP;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_RESP;
                end
            end
            S_PUT: begin
                o_cmd.put_wr = 1'b1;
                n_state      = S_RESP;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/pbs_datapath.sv =====
// pbs_datapath: frame registers, address math, pixel memory and result register.
// Commanded by pbs_ctrl; uses pbs_pkg.
`timescale 1ns / 1ps

module pbs_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_index,
    input  logic [pbs_pkg::CFG_W-1:0]    i_cfg_data,
    input  pbs_pkg::t_in_beat            i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output pbs_pkg::t_out_beat           o_out,
    input  pbs_pkg::t_cmd                i_cmd,
    output pbs_pkg::t_sts                o_sts
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    logic [8:0] r_frame_width;
    logic [8:0] r_frame_height;

    logic [8:0]  w_act;
    logic [8:0]  h_act;
    logic [17:0] w_area;
    logic [18:0] w_lin;
    logic        w_col_oor;
    logic        w_row_oor;
    logic        w_op_pixel;
    pbs_pkg::t_pixel w_put_pix;
    pbs_pkg::t_pixel w_def_pix;
    pbs_pkg::t_pixel w_wr_pix;
    logic [AW-1:0]   w_wr_addr;

    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_clr_cnt;
    logic [AW-1:0]   r_clr_last;
    logic            r_status;
    logic            r_get_ok;
    pbs_pkg::t_pixel r_put_pix;
    pbs_pkg::t_pixel r_rd;
    pbs_pkg::t_pixel r_mem [STORE_SIZE];

    logic               r_out_valid;
    pbs_pkg::t_out_beat r_out;
    pbs_pkg::t_out_beat n_out;

    function automatic logic [11:0] clamp_int(input logic signed [15:0] x);
        logic [11:0] res;
        if (x[15]) begin
            res = '0;
        end else if (x > 16'sd4095) begin
            res = pbs_pkg::INTENSITY_MAX;
        end else begin
            res = x[11:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= pbs_pkg::CFG_RESET_DIM;
            r_frame_height <= pbs_pkg::CFG_RESET_DIM;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pbs_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                pbs_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_act  = (32'(r_frame_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : r_frame_width;
    assign h_act  = (32'(r_frame_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : r_frame_height;
    assign w_area = 18'(w_act) * 18'(h_act);

    assign w_col_oor  = i_in.column[15] || (16'(i_in.column) >= 16'(w_act));
    assign w_row_oor  = i_in.row[15] || (16'(i_in.row) >= 16'(h_act));
    assign w_op_pixel = (i_in.operation == pbs_pkg::OP_PUT) ||
                        (i_in.operation == pbs_pkg::OP_GET);
    // in range: row < 512 and col < 512, so low nine bits carry the value
    assign w_lin = 19'(i_in.row[8:0]) * 19'(w_act) + 19'(i_in.column[8:0]);

    assign w_put_pix.red   = clamp_int(i_in.red_in);
    assign w_put_pix.green = clamp_int(i_in.green_in);
    assign w_put_pix.blue  = clamp_int(i_in.blue_in);
    assign w_put_pix.alpha = i_in.alpha_in;
    assign w_put_pix.depth = i_in.depth_in;

    assign w_def_pix.red   = pbs_pkg::DEF_RED;
    assign w_def_pix.green = pbs_pkg::DEF_GREEN;
    assign w_def_pix.blue  = pbs_pkg::DEF_BLUE;
    assign w_def_pix.alpha = pbs_pkg::DEF_ALPHA;
    assign w_def_pix.depth = pbs_pkg::DEF_DEPTH;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr     <= AW'(w_lin);
            r_clr_last <= AW'(w_area - 18'd1);
            r_put_pix  <= w_put_pix;
            r_status   <= w_op_pixel && (w_col_oor || w_row_oor);
            r_get_ok   <= (i_in.operation == pbs_pkg::OP_GET) && !(w_col_oor || w_row_oor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.capture) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    assign w_wr_addr = i_cmd.clr_wr ? r_clr_cnt : r_addr;
    assign w_wr_pix  = i_cmd.clr_wr ? w_def_pix : r_put_pix;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr || i_cmd.put_wr) begin
            r_mem[w_wr_addr] <= w_wr_pix;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_comb begin
        n_out        = '0;
        n_out.status = r_status;
        if (r_get_ok) begin
            n_out.red_out    = r_rd.red;
            n_out.green_out  = r_rd.green;
            n_out.blue_out   = r_rd.blue;
            n_out.alpha_out  = r_rd.alpha;
            n_out.depth_out  = r_rd.depth;
            n_out.red_byte   = r_rd.red[11:4];
            n_out.green_byte = r_rd.green[11:4];
            n_out.blue_byte  = r_rd.blue[11:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_sts.in_op     = i_in.operation;
    assign o_sts.in_oor    = w_col_oor || w_row_oor;
    assign o_sts.clr_empty = (w_area == 18'd0);
    assign o_sts.clr_last  = (r_clr_cnt == r_clr_last);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ===== src/pixel_buffer_store.sv =====
// pixel_buffer_store: top level of the per-pixel color, alpha and depth store.
// Joins pbs_ctrl and pbs_datapath; uses pbs_pkg.
//
// Channel  Handshake                  Payload
// in       i_in_valid / o_in_stall    pbs_pkg::t_in_beat  i_in
// out      o_out_valid / i_out_stall  pbs_pkg::t_out_beat o_out
// cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Puts and gets pass a write or read state, then the response state that loads
// the result register; unused-code and out-of-range beats, and a clear of an
// empty frame, skip to it; a clear writes width*height pixels, one pixel memory
// write per cycle. One beat in flight; the next is taken the cycle after its
// result is registered; a result stalled by i_out_stall holds the next one.
// Reset sets both frame registers to 256; pixel memory is not initialized.
`timescale 1ns / 1ps

module pixel_buffer_store #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  pbs_pkg::t_in_beat         i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output pbs_pkg::t_out_beat        o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [pbs_pkg::CFG_W-1:0] i_cfg_data
);

    pbs_pkg::t_cmd w_cmd;
    pbs_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    pbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pbs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule
